@@ sv/gpc_pkg.sv @@
`default_nettype none

package gpc_pkg;

    localparam logic [7:0] BYTE_MAX   = 8'hFF;
    localparam logic [7:0] ROUND_BIAS = 8'd127;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_TINT_BLUE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_GREEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_RED     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_OPACITY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_COV   = 3'd4;

    localparam int unsigned LANES = 4;

    typedef struct packed {
        logic [7:0] tint_blue;
        logic [7:0] tint_green;
        logic [7:0] tint_red;
        logic [7:0] tint_opacity;
        logic       invert_coverage;
    } gpc_cfg_t;

    // Load strobes for the two lane stages.
    typedef struct packed {
        logic ld1;
        logic ld2;
    } gpc_adv_t;

    // Rounded byte product (a*b + 127) / 255, division done as add-and-shift.
    // Exact for quotients up to 256, and the product here stays below that.
    function automatic logic [7:0] mul8(input logic [7:0] a, input logic [7:0] b);
        logic [15:0] p;
        logic [16:0] t;
        logic [17:0] u;
        begin
            p = 16'(a) * 16'(b);
            t = 17'(p) + 17'(ROUND_BIAS);
            u = 18'(t) + 18'(t >> 8) + 18'd1;
            return u[15:8];
        end
    endfunction

endpackage

`default_nettype wire

@@ sv/gpc_if.sv @@
`default_nettype none

interface gpc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_blue;
    logic [7:0] src_green;
    logic [7:0] src_red;
    logic [7:0] src_alpha;
    logic [7:0] dst_blue;
    logic [7:0] dst_green;
    logic [7:0] dst_red;
    logic [7:0] dst_alpha;
    logic       colored_glyph;
    logic       row_end_in;

    modport source (
        output valid, src_blue, src_green, src_red, src_alpha,
               dst_blue, dst_green, dst_red, dst_alpha, colored_glyph, row_end_in,
        input  ready
    );
    modport sink (
        input  valid, src_blue, src_green, src_red, src_alpha,
               dst_blue, dst_green, dst_red, dst_alpha, colored_glyph, row_end_in,
        output ready
    );
endinterface

interface gpc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_alpha;
    logic       row_end_out;

    modport source (
        output valid, out_blue, out_green, out_red, out_alpha, row_end_out,
        input  ready
    );
    modport sink (
        input  valid, out_blue, out_green, out_red, out_alpha, row_end_out,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/gpc_cfg.sv @@
`default_nettype none

module gpc_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [gpc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [7:0]                     wr_data,
    output gpc_pkg::gpc_cfg_t                   cfg
);
    import gpc_pkg::*;

    gpc_cfg_t cfg_reg;
    gpc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_TINT_BLUE:    cfg_next.tint_blue       = wr_data;
                REG_TINT_GREEN:   cfg_next.tint_green      = wr_data;
                REG_TINT_RED:     cfg_next.tint_red        = wr_data;
                REG_TINT_OPACITY: cfg_next.tint_opacity    = wr_data;
                REG_INVERT_COV:   cfg_next.invert_coverage = wr_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tint_blue       <= 8'd0;
            cfg_reg.tint_green      <= 8'd0;
            cfg_reg.tint_red        <= 8'd0;
            cfg_reg.tint_opacity    <= BYTE_MAX;
            cfg_reg.invert_coverage <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ sv/gpc_lane.sv @@
`default_nettype none

// One channel of the blend. Stage 1 forms the coverage (or scaled source),
// stage 2 forms the source term and the destination term.
module gpc_lane (
    input  wire logic               clk,
    input  gpc_pkg::gpc_adv_t       adv,
    input  wire logic [7:0]         src,
    input  wire logic [7:0]         dst,
    input  wire logic               colored,
    input  wire logic               invert,
    input  wire logic [7:0]         opacity,
    input  wire logic [7:0]         tint,
    input  wire logic [7:0]         sa_shared,
    output logic [7:0]              cov,
    output logic [7:0]              s_term,
    output logic [7:0]              d_term
);
    import gpc_pkg::*;

    logic [7:0] cov_reg;
    logic [7:0] dst_reg;
    logic       col_reg;
    logic [7:0] s_reg;
    logic [7:0] m_reg;
    logic [7:0] g;
    logic [7:0] sa_eff;

    assign g      = (!colored && invert) ? ~src : src;
    assign sa_eff = col_reg ? sa_shared : cov_reg;

    always_ff @(posedge clk)
    begin
        if (adv.ld1)
        begin
            cov_reg <= mul8(g, opacity);
            dst_reg <= dst;
            col_reg <= colored;
        end
        if (adv.ld2)
        begin
            s_reg <= col_reg ? cov_reg : mul8(tint, cov_reg);
            m_reg <= mul8(dst_reg, BYTE_MAX - sa_eff);
        end
    end

    assign cov    = cov_reg;
    assign s_term = s_reg;
    assign d_term = m_reg;

endmodule

`default_nettype wire

@@ sv/gpc_merge.sv @@
`default_nettype none

// Saturating sum of each lane's terms into the output register.
module gpc_merge (
    input  wire logic       clk,
    input  wire logic       ld,
    input  wire logic [7:0] s_term [gpc_pkg::LANES],
    input  wire logic [7:0] d_term [gpc_pkg::LANES],
    input  wire logic       row_end,
    output logic [7:0]      px_reg [gpc_pkg::LANES],
    output logic            row_end_reg
);
    import gpc_pkg::*;

    logic [8:0] sum  [LANES];
    logic [7:0] sat  [LANES];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            sum[i] = {1'b0, s_term[i]} + {1'b0, d_term[i]};
            sat[i] = sum[i][8] ? BYTE_MAX : sum[i][7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            px_reg      <= sat;
            row_end_reg <= row_end;
        end
    end

endmodule

`default_nettype wire

@@ sv/glyph_pixel_compositor.sv @@
`default_nettype none

// Glyph pixel compositor: blends one glyph pixel onto one premultiplied
// destination pixel with source-over, one beat in, one beat out.
//
// pixel   : input beats (glyph bytes, destination bytes, glyph kind, row end).
// blended : result beats; row_end_out copies the row end of the same beat.
// wr_*    : register writes, taken at any edge with wr_en high; write only
//           while no beat is in flight.
//
// Four lanes (blue, green, red, alpha) run a three-stage pipeline: coverage
// product, source and destination products, saturating add into the output
// register. An accepted beat passes through these stages in order.
// Throughput is one beat per clock while blended.ready is high; each stage
// takes a new beat as soon as the one ahead moves on, so a stalled output only
// backs up as far as needed. Reset empties the pipeline and loads tints 0,
// opacity 255, no inversion. While blended.ready is low the output beat
// holds and the earlier stages fill, then pixel.ready drops.
module glyph_pixel_compositor (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    gpc_in_if.sink                              pixel,
    gpc_out_if.source                           blended,
    input  wire logic                           wr_en,
    input  wire logic [gpc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [7:0]                     wr_data
);
    import gpc_pkg::*;

    gpc_cfg_t   cfg;
    gpc_adv_t   adv;

    logic       v1_reg, v2_reg, v3_reg;
    logic       v1_next, v2_next, v3_next;
    logic       re1_reg, re2_reg;
    logic       rdy1, rdy2, rdy3;
    logic       ld3;

    logic [7:0] src   [LANES];
    logic [7:0] dst   [LANES];
    logic [7:0] tint  [LANES];
    logic [7:0] cov   [LANES];
    logic [7:0] s_term[LANES];
    logic [7:0] d_term[LANES];
    logic [7:0] px    [LANES];
    logic       row_end_q;

    gpc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    // Stage handshake: a stage is free when empty or when its beat moves on.
    assign rdy3    = !v3_reg || blended.ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign adv.ld1 = pixel.valid && rdy1;
    assign adv.ld2 = v1_reg && rdy2;
    assign ld3     = v2_reg && rdy3;

    assign v1_next = adv.ld1 || (v1_reg && !rdy2);
    assign v2_next = adv.ld2 || (v2_reg && !rdy3);
    assign v3_next = ld3 || (v3_reg && !blended.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.ld1)
        begin
            re1_reg <= pixel.row_end_in;
        end
        if (adv.ld2)
        begin
            re2_reg <= re1_reg;
        end
    end

    assign src[0]  = pixel.src_blue;
    assign src[1]  = pixel.src_green;
    assign src[2]  = pixel.src_red;
    assign src[3]  = pixel.src_alpha;
    assign dst[0]  = pixel.dst_blue;
    assign dst[1]  = pixel.dst_green;
    assign dst[2]  = pixel.dst_red;
    assign dst[3]  = pixel.dst_alpha;
    assign tint[0] = cfg.tint_blue;
    assign tint[1] = cfg.tint_green;
    assign tint[2] = cfg.tint_red;
    assign tint[3] = BYTE_MAX;

    // Color lanes: a colored glyph takes its alpha from the alpha lane.
    for (genvar i = 0; i < LANES - 1; i++)
    begin : g_color
        gpc_lane u_lane (
            .clk       (clk),
            .adv       (adv),
            .src       (src[i]),
            .dst       (dst[i]),
            .colored   (pixel.colored_glyph),
            .invert    (cfg.invert_coverage),
            .opacity   (cfg.tint_opacity),
            .tint      (tint[i]),
            .sa_shared (cov[LANES-1]),
            .cov       (cov[i]),
            .s_term    (s_term[i]),
            .d_term    (d_term[i])
        );
    end

    // Alpha lane: same math in both glyph kinds, never inverted.
    gpc_lane u_alpha (
        .clk       (clk),
        .adv       (adv),
        .src       (src[LANES-1]),
        .dst       (dst[LANES-1]),
        .colored   (1'b1),
        .invert    (1'b0),
        .opacity   (cfg.tint_opacity),
        .tint      (tint[LANES-1]),
        .sa_shared (cov[LANES-1]),
        .cov       (cov[LANES-1]),
        .s_term    (s_term[LANES-1]),
        .d_term    (d_term[LANES-1])
    );

    gpc_merge u_merge (
        .clk         (clk),
        .ld          (ld3),
        .s_term      (s_term),
        .d_term      (d_term),
        .row_end     (re2_reg),
        .px_reg      (px),
        .row_end_reg (row_end_q)
    );

    assign pixel.ready         = rdy1;
    assign blended.valid       = v3_reg;
    assign blended.out_blue    = px[0];
    assign blended.out_green   = px[1];
    assign blended.out_red     = px[2];
    assign blended.out_alpha   = px[3];
    assign blended.row_end_out = row_end_q;

endmodule

`default_nettype wire
